// File: src/cbm_pkg.sv
// Shared types and constants for the cartridge bank mapper.
package cbm_pkg;

  localparam int unsigned AddrW    = 16;
  localparam int unsigned DataW    = 8;
  localparam int unsigned MemAddrW = 21;
  localparam int unsigned RomBankW = 7;
  localparam int unsigned RamBankW = 2;
  localparam int unsigned LatchW   = 5;

  typedef logic [1:0] target_t;
  localparam target_t TGT_REG = 2'd0;
  localparam target_t TGT_ROM = 2'd1;
  localparam target_t TGT_RAM = 2'd2;
  localparam target_t TGT_SYS = 2'd3;

  // Bus regions of 8 KiB each, taken from the top three address bits.
  typedef logic [2:0] region_t;
  localparam region_t RGN_RAM_EN   = 3'd0;
  localparam region_t RGN_ROM_LOW  = 3'd1;
  localparam region_t RGN_ROM_HIGH = 3'd2;
  localparam region_t RGN_MODE     = 3'd3;
  localparam region_t RGN_CART_RAM = 3'd5;

  localparam logic [DataW-1:0] RamEnableKey = 8'h0A;
  localparam logic [DataW-1:0] BankHoleMask = 8'h9F;

  typedef struct packed {
    logic             mode;
    logic [AddrW-1:0] bus_address;
    logic [DataW-1:0] write_data;
  } in_item_t;

  typedef struct packed {
    target_t             target;
    logic [MemAddrW-1:0] mem_address;
    logic                is_write;
    logic [DataW-1:0]    data_out;
  } out_item_t;

  typedef struct packed {
    logic                bank_mode;
    logic                ram_enable;
    logic [RomBankW-1:0] rom_bank;
    logic [RamBankW-1:0] ram_bank;
    logic [LatchW-1:0]   low_bank_latch;
  } bank_state_t;

endpackage

// File: src/cbm_decode.sv
// Access decode: register updates and address translation for one bus access.
module cbm_decode import cbm_pkg::*; (
  input  in_item_t    item,
  input  bank_state_t state,
  input  logic        sram_present,
  output out_item_t   result,
  output bank_state_t state_nxt
);

  region_t             region;
  logic [DataW-1:0]    low_v;
  logic [RomBankW-1:0] high_v;
  logic [MemAddrW-1:0] rom_addr;
  logic [MemAddrW-1:0] ram_addr;
  logic [MemAddrW-1:0] sys_addr;

  assign region   = item.bus_address[AddrW-1 -: 3];
  assign rom_addr = {state.rom_bank, item.bus_address[13:0]};
  assign ram_addr = {{(MemAddrW-RamBankW-13){1'b0}}, state.ram_bank, item.bus_address[12:0]};
  assign sys_addr = {{(MemAddrW-AddrW){1'b0}}, item.bus_address};

  // Bank numbers that would select bank zero of a quadrant are bumped by one.
  always_comb begin
    low_v = item.write_data;
    if ((item.write_data & BankHoleMask) == '0) begin
      low_v = item.write_data + 8'd1;
    end
    high_v = {item.write_data[1:0], state.low_bank_latch};
    if (high_v[LatchW-1:0] == '0) begin
      high_v = high_v + 7'd1;
    end
  end

  always_comb begin
    state_nxt = state;
    result    = '{target: TGT_SYS, mem_address: sys_addr, is_write: item.mode,
                  data_out: item.mode ? item.write_data : '0};
    if (item.mode) begin
      case (region)
        RGN_RAM_EN: begin
          state_nxt.ram_enable = ((item.write_data & RamEnableKey) == RamEnableKey);
          result = '0;
        end
        RGN_ROM_LOW: begin
          if (state.bank_mode) begin
            state_nxt.rom_bank = {2'b00, low_v[LatchW-1:0]};
          end else begin
            state_nxt.low_bank_latch = low_v[LatchW-1:0];
          end
          result = '0;
        end
        RGN_ROM_HIGH: begin
          if (state.bank_mode) begin
            state_nxt.ram_bank = item.write_data[RamBankW-1:0];
          end else begin
            state_nxt.rom_bank = high_v;
          end
          result = '0;
        end
        RGN_MODE: begin
          state_nxt.bank_mode = (item.write_data != '0);
          result = '0;
        end
        RGN_CART_RAM: begin
          // Cartridge RAM writes do not look at the RAM enable.
          if (sram_present) begin
            result.target      = TGT_RAM;
            result.mem_address = ram_addr;
          end
        end
        default: ;
      endcase
    end else begin
      case (region)
        RGN_RAM_EN, RGN_ROM_LOW: begin
          result.target = TGT_ROM;
        end
        RGN_ROM_HIGH, RGN_MODE: begin
          result.target      = TGT_ROM;
          result.mem_address = rom_addr;
        end
        RGN_CART_RAM: begin
          if (sram_present && state.ram_enable) begin
            result.target      = TGT_RAM;
            result.mem_address = ram_addr;
          end
        end
        default: ;
      endcase
    end
  end

endmodule

// File: src/cartridge_bank_mapper.sv
// Top level of the cartridge bank mapper: input and result registers, bank state.
//
// Each item is one CPU bus access; each yields exactly one result item. An
// accepted item sits in the input register while it is decoded against the
// bank state, then moves to the result register, and a new item is taken
// every cycle while the result side keeps up. Bank state is updated on the
// edge the item leaves the input register, so a following access already
// sees the new banks. Write cfg_sram_present only while no item is in
// flight.
module cartridge_bank_mapper import cbm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item,
  input  logic      cfg_we,
  input  logic      cfg_sram_present
);

  logic        in_valid_r;
  in_item_t    in_item_r;
  logic        out_valid_r;
  out_item_t   out_item_r;
  bank_state_t state_r;
  bank_state_t state_nxt;
  logic        sram_present_r;
  out_item_t   result;
  logic        advance;
  logic        load_in;

  // The input register may also fill while the result side is stalled, as long as it is empty.
  assign advance  = !out_valid_r || !out_stall;
  assign load_in  = advance || !in_valid_r;
  assign in_stall = !load_in;

  cbm_decode u_decode (
    .item         (in_item_r),
    .state        (state_r),
    .sram_present (sram_present_r),
    .result       (result),
    .state_nxt    (state_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      sram_present_r <= 1'b0;
      state_r        <= '{bank_mode: 1'b0, ram_enable: 1'b0, rom_bank: 7'd1,
                          ram_bank: '0, low_bank_latch: '0};
    end else begin
      if (cfg_we) begin
        sram_present_r <= cfg_sram_present;
      end
      if (advance) begin
        out_valid_r <= in_valid_r;
        if (in_valid_r) begin
          state_r <= state_nxt;
        end
      end
      if (load_in) begin
        in_valid_r <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_in) begin
      in_item_r <= in_item;
    end
    if (advance) begin
      out_item_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

endmodule

// File: verif/cbm_checker.sv
// Checker for the cartridge bank mapper: predicts each translated access and compares results.
module cbm_checker import cbm_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_stall,
  input  in_item_t  in_item,
  input  logic      out_valid,
  input  logic      out_stall,
  input  out_item_t out_item,
  input  logic      cfg_we,
  input  logic      cfg_sram_present,
  output int        mismatch_count,
  output int        awaited_count
);
  timeunit 1ns;
  timeprecision 1ps;

  bank_state_t banks;
  logic        sram_fitted;
  out_item_t   awaited_q[$];
  int          fails;

  // Works out the translation of one bus access and applies any bank register update.
  function automatic out_item_t translate_access(in_item_t acc);
    out_item_t           res;
    region_t             rgn;
    logic [DataW-1:0]    low_sel;
    logic [RomBankW-1:0] joined;
    logic [MemAddrW-1:0] cart_addr;
    rgn       = acc.bus_address[AddrW-1:AddrW-3];
    cart_addr = MemAddrW'({banks.ram_bank, acc.bus_address[12:0]});
    res             = '0;
    res.target      = TGT_SYS;
    res.mem_address = MemAddrW'(acc.bus_address);
    res.is_write    = acc.mode;
    res.data_out    = acc.mode ? acc.write_data : '0;
    if (acc.mode) begin
      case (rgn)
        RGN_RAM_EN: begin
          banks.ram_enable = (acc.write_data & RamEnableKey) == RamEnableKey;
          res = '0;
        end
        RGN_ROM_LOW: begin
          // Bank numbers with nothing outside bits 5 and 6 select the next bank up.
          low_sel = acc.write_data;
          if ((low_sel & BankHoleMask) == '0) low_sel = low_sel + 8'd1;
          if (banks.bank_mode) banks.rom_bank = RomBankW'(low_sel[LatchW-1:0]);
          else banks.low_bank_latch = low_sel[LatchW-1:0];
          res = '0;
        end
        RGN_ROM_HIGH: begin
          if (banks.bank_mode) begin
            banks.ram_bank = acc.write_data[RamBankW-1:0];
          end else begin
            joined = {acc.write_data[RamBankW-1:0], banks.low_bank_latch};
            if (joined[LatchW-1:0] == '0) joined = joined + 7'd1;
            banks.rom_bank = joined;
          end
          res = '0;
        end
        RGN_MODE: begin
          banks.bank_mode = acc.write_data != '0;
          res = '0;
        end
        RGN_CART_RAM: begin
          // Cartridge RAM writes do not look at the RAM enable.
          if (sram_fitted) begin
            res.target      = TGT_RAM;
            res.mem_address = cart_addr;
          end
        end
        default: ;
      endcase
    end else begin
      case (rgn)
        RGN_RAM_EN, RGN_ROM_LOW: res.target = TGT_ROM;
        RGN_ROM_HIGH, RGN_MODE: begin
          res.target      = TGT_ROM;
          res.mem_address = {banks.rom_bank, acc.bus_address[13:0]};
        end
        RGN_CART_RAM: begin
          if (sram_fitted && banks.ram_enable) begin
            res.target      = TGT_RAM;
            res.mem_address = cart_addr;
          end
        end
        default: ;
      endcase
    end
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (!rst_n) begin
      banks          = '0;
      banks.rom_bank = RomBankW'(1);
      sram_fitted    = 1'b0;
      fails          = 0;
      awaited_q.delete();
      mismatch_count <= 0;
      awaited_count  <= 0;
    end else begin
      if (cfg_we) sram_fitted = cfg_sram_present;
      if (out_valid && !out_stall) begin
        if (awaited_q.size() == 0) begin
          if (fails < 10)
            $display("%0t: unexpected result item target=%0d addr=%06h wr=%0d data=%02h",
                     $realtime, out_item.target, out_item.mem_address, out_item.is_write,
                     out_item.data_out);
          fails++;
        end else begin
          want = awaited_q.pop_front();
          if (want.target != out_item.target || want.mem_address != out_item.mem_address ||
              want.is_write != out_item.is_write || want.data_out != out_item.data_out) begin
            if (fails < 10)
              $display({"%0t: mismatch, expected target=%0d addr=%06h wr=%0d data=%02h,",
                        " got target=%0d addr=%06h wr=%0d data=%02h"}, $realtime,
                       want.target, want.mem_address, want.is_write, want.data_out,
                       out_item.target, out_item.mem_address, out_item.is_write,
                       out_item.data_out);
            fails++;
          end
        end
      end
      if (in_valid && !in_stall) awaited_q.push_back(translate_access(in_item));
      mismatch_count <= fails;
      awaited_count  <= awaited_q.size();
    end
  end

endmodule

// File: verif/tb_top.sv
// Testbench top for the cartridge bank mapper: clock, reset, stimulus and verdict.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cbm_pkg::*;

  localparam int unsigned CycleLimit  = 200000;
  localparam int unsigned RandomItems = 1700;
  localparam int unsigned NumPhases   = 6;
  localparam logic [NumPhases-1:0] SramPlan = 6'b101101;

  logic      clk              = 1'b0;
  logic      rst_n            = 1'b0;
  logic      in_valid         = 1'b0;
  in_item_t  in_item          = '0;
  logic      out_stall        = 1'b0;
  logic      cfg_we           = 1'b0;
  logic      cfg_sram_present = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_item;

  int          mismatches;
  int          in_flight;
  int unsigned cycle_count = 0;
  int unsigned stall_style = 0;
  int unsigned stall_left  = 0;

  always #6 clk = ~clk;

  cartridge_bank_mapper i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_item          (in_item),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_item         (out_item),
    .cfg_we           (cfg_we),
    .cfg_sram_present (cfg_sram_present)
  );

  cbm_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_item          (in_item),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_item         (out_item),
    .cfg_we           (cfg_we),
    .cfg_sram_present (cfg_sram_present),
    .mismatch_count   (mismatches),
    .awaited_count    (in_flight)
  );

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("FAIL");
      $finish;
    end
  end

  // The result side changes its stall habit every so often: none, light, heavy or periodic.
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_left  <= $urandom_range(40, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 2) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= ((cycle_count % 7) < 3);
    endcase
  end

  function automatic in_item_t make_access(logic wr, logic [AddrW-1:0] addr,
                                           logic [DataW-1:0] data);
    in_item_t acc;
    acc.mode        = wr;
    acc.bus_address = addr;
    acc.write_data  = data;
    return acc;
  endfunction

  // Data for bank register writes, leaning towards bank numbers that get bumped.
  function automatic logic [DataW-1:0] bank_value();
    logic [DataW-1:0] val;
    val = DataW'($urandom_range(0, 255));
    case ($urandom_range(0, 7))
      0:       val = '0;
      1:       val = {1'b0, 2'($urandom_range(0, 3)), 5'b0};
      2:       val = RamEnableKey | DataW'($urandom_range(0, 255) & 8'hF0);
      3:       val = DataW'($urandom_range(0, 3));
      default: ;
    endcase
    return val;
  endfunction

  function automatic in_item_t random_access();
    in_item_t acc;
    acc.mode        = 1'($urandom_range(0, 1));
    acc.bus_address = AddrW'($urandom_range(0, 16'hFFFF));
    acc.write_data  = DataW'($urandom_range(0, 255));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: begin
        acc.mode               = 1'b1;
        acc.bus_address[AddrW-1] = 1'b0;
        acc.write_data         = bank_value();
      end
      4, 5: begin
        acc.mode               = 1'b0;
        acc.bus_address[AddrW-1] = 1'b0;
      end
      6, 7: acc.bus_address[AddrW-1:AddrW-3] = RGN_CART_RAM;
      default: ;
    endcase
    return acc;
  endfunction

  task automatic issue(input in_item_t acc);
    in_item  <= acc;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (in_flight != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_sram_present(input logic present);
    cfg_we           <= 1'b1;
    cfg_sram_present <= present;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int unsigned burst_left;
    int unsigned gap;
    burst_left = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_sram_present(1'b1);
    issue(make_access(1'b0, 16'h0000, 8'h00));
    issue(make_access(1'b0, 16'h3FFF, 8'hFF));
    issue(make_access(1'b0, 16'h4000, 8'h00));
    issue(make_access(1'b0, 16'h7FFF, 8'h00));
    // RAM still disabled: reads fall through to system memory, writes do not.
    issue(make_access(1'b0, 16'hA000, 8'h00));
    issue(make_access(1'b1, 16'hA000, 8'h55));
    issue(make_access(1'b1, 16'h0000, 8'h0A));
    issue(make_access(1'b0, 16'hBFFF, 8'h00));
    issue(make_access(1'b1, 16'h2000, 8'h00));
    issue(make_access(1'b1, 16'h2000, 8'h60));
    issue(make_access(1'b1, 16'h3FFF, 8'hFF));
    issue(make_access(1'b1, 16'h4000, 8'h03));
    issue(make_access(1'b0, 16'h7FFF, 8'h00));
    issue(make_access(1'b1, 16'h2000, 8'hE0));
    issue(make_access(1'b1, 16'h5FFF, 8'h01));
    issue(make_access(1'b0, 16'h4000, 8'h00));
    issue(make_access(1'b1, 16'h6000, 8'h01));
    issue(make_access(1'b1, 16'h4000, 8'h03));
    issue(make_access(1'b1, 16'h2000, 8'h00));
    issue(make_access(1'b0, 16'hBFFF, 8'hFF));
    issue(make_access(1'b1, 16'h1FFF, 8'h00));
    issue(make_access(1'b0, 16'hA000, 8'h00));
    issue(make_access(1'b1, 16'h8000, 8'hFF));
    issue(make_access(1'b0, 16'hFFFF, 8'hFF));
    issue(make_access(1'b1, 16'h7FFF, 8'h00));
    settle();

    for (int p = 0; p < NumPhases; p++) begin
      write_sram_present(SramPlan[p]);
      for (int n = 0; n < RandomItems / NumPhases; n++) begin
        if (burst_left == 0) begin
          gap = $urandom_range(0, 6);
          if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
          end
          burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 250)
                                                   : $urandom_range(1, 30);
        end
        issue(random_access());
        burst_left--;
      end
      settle();
    end

    if (mismatches == 0 && in_flight == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
src/cbm_pkg.sv
src/cbm_decode.sv
src/cartridge_bank_mapper.sv
verif/cbm_checker.sv
verif/tb_top.sv
